FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rational gcd reduce rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked every clock, off while in reset
`define RAG_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("rag check failed");
// property checked every clock, also during reset
`define RAG_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) else $error("rag check failed");
`else
`define RAG_ASSERT(lbl, clk, rstn, prop)
`define RAG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hw/rtl/rag_pkg.sv
// ----------------------------------------------------------------------------
// rag_pkg
// types, codes and constants of the rational gcd reduce block
// ----------------------------------------------------------------------------
package rag_pkg;

	localparam int DEFAULT_WIDTH = 32;

	// operation codes
	typedef enum logic [2:0] {
		OP_NORM    = 3'd0,
		OP_ADD     = 3'd1,
		OP_ADD_INT = 3'd2,
		OP_SUB_INT = 3'd3,
		OP_EQ      = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
		logic signed [31:0] int_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic signed [31:0] res_den;
		logic               is_equal;
		logic               divide_error;
	} rsp_t;

	// multiplier operand pairs
	typedef enum logic [1:0] {
		MUL_AN_BD,
		MUL_BN_AD,
		MUL_AD_BD,
		MUL_IV_AD
	} mul_sel_t;

	// divider operand pairs
	typedef enum logic [1:0] {
		DIV_X_Y,
		DIV_N_Y,
		DIV_D_Y
	} div_sel_t;

	// register write actions
	typedef enum logic [3:0] {
		WR_NONE,
		WR_N_AN_D_AD,
		WR_N_P,
		WR_N_ADD_P,
		WR_INT,
		WR_D_P,
		WR_EQ,
		WR_XY_INIT,
		WR_STEP,
		WR_RN_Q,
		WR_RD_Q,
		WR_ERR
	} wr_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     div_start;
		div_sel_t div_sel;
		wr_t      wr;
		logic     out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       mul_done;
		logic       div_done;
		logic       d_zero;
		logic       rem_zero;
	} dp_status_t;

endpackage

FILE: hw/rtl/rational_arith_gcd_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_gcd_reduce
// rational add, integer add/subtract, normalize and equality; all but
// equality end in euclid gcd reduction
// ----------------------------------------------------------------------------
// channel | valid     | stall     | payload
// request | req_valid | req_stall | req (rag_pkg::req_t)
// result  | rsp_valid | rsp_stall | rsp (rag_pkg::rsp_t)
//
// units: products are formed on the shift-add multiplier, quotients and
//   euclid remainders on the restoring divider; add takes three products.
// one request is worked at a time; the next is taken once the result sits
//   in the output register.
// reset clears the controller and the output valid; no clearing pass.
// a stalled result holds in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arith_gcd_reduce #(
	parameter int WIDTH = rag_pkg::DEFAULT_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rag_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rag_pkg::rsp_t rsp
);

	rag_pkg::ctl_cmd_t   cmd;
	rag_pkg::dp_status_t status;
	rag_pkg::rsp_t       res;
	logic                rsp_valid_q;
	rag_pkg::rsp_t       rsp_q;
	logic                out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	rag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.out_free  (out_free),
		.status    (status),
		.cmd       (cmd)
	);

	rag_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			rsp_q <= res;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RAG_ASSERT(a_no_overwrite, clk, arst_n, cmd.out_load |-> (!rsp_valid_q || !rsp_stall))
	`RAG_ASSERT(a_eq_clean, clk, arst_n,
		(rsp_valid && rsp.is_equal) |-> (rsp.res_num == 32'sd0 && !rsp.divide_error))
	`RAG_ASSERT(a_err_zero, clk, arst_n,
		(rsp_valid && rsp.divide_error) |-> (rsp.res_num == 32'sd0 && rsp.res_den == 32'sd0))

endmodule

FILE: hw/rtl/rag_dp.sv
// ----------------------------------------------------------------------------
// rag_dp
// operand registers, shift-add multiplier and restoring divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rag_dp #(
	parameter int WIDTH = rag_pkg::DEFAULT_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rag_pkg::req_t         req,
	input  rag_pkg::ctl_cmd_t     cmd,
	output rag_pkg::dp_status_t   status,
	output rag_pkg::rsp_t         res
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic [2:0]              op_q;
	logic signed [WIDTH-1:0] an_q, ad_q, bn_q, bd_q, iv_q;
	logic signed [WIDTH-1:0] n_q, d_q, x_q, y_q;
	logic signed [WIDTH-1:0] rn_q, rd_q;
	logic                    eq_q, err_q;

	// multiplier state
	logic             mul_busy_q, mul_done_q;
	logic [CW-1:0]    mul_cnt_q;
	logic [WIDTH-1:0] mcand_q, mplier_q, prod_q;

	// divider state
	logic             div_busy_q, div_done_q;
	logic [CW-1:0]    div_cnt_q;
	logic [WIDTH-1:0] dvd_q, dvs_q, quo_q, rem_q;
	logic             sa_q, sb_q;

	logic [WIDTH-1:0] mul_a, mul_b;
	logic [WIDTH-1:0] div_a, div_b;
	logic [WIDTH:0]   rem_sh, diff;
	logic [WIDTH-1:0] q_res, r_res;

	// operand pair selection
	always_comb begin
		unique case (cmd.mul_sel)
			rag_pkg::MUL_AN_BD: begin mul_a = an_q; mul_b = bd_q; end
			rag_pkg::MUL_BN_AD: begin mul_a = bn_q; mul_b = ad_q; end
			rag_pkg::MUL_AD_BD: begin mul_a = ad_q; mul_b = bd_q; end
			default:            begin mul_a = iv_q; mul_b = ad_q; end
		endcase
		unique case (cmd.div_sel)
			rag_pkg::DIV_N_Y: begin div_a = n_q; div_b = y_q; end
			rag_pkg::DIV_D_Y: begin div_a = d_q; div_b = y_q; end
			default:          begin div_a = x_q; div_b = y_q; end
		endcase
	end

	// one restoring step and sign fix of the results
	assign rem_sh = {rem_q, dvd_q[WIDTH-1]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign q_res  = (sa_q ^ sb_q) ? (WIDTH'(0) - quo_q) : quo_q;
	assign r_res  = sa_q ? (WIDTH'(0) - rem_q) : rem_q;

	// shift-add multiplier, low bits only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_done_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else begin
			mul_done_q <= 1'b0;
			if (cmd.mul_start) begin
				mul_busy_q <= 1'b1;
				mul_cnt_q  <= '0;
			end else if (mul_busy_q) begin
				mul_cnt_q <= mul_cnt_q + CW'(1);
				if (mul_cnt_q == CW'(WIDTH - 1)) begin
					mul_busy_q <= 1'b0;
					mul_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mcand_q  <= mul_a;
			mplier_q <= mul_b;
			prod_q   <= '0;
		end else if (mul_busy_q) begin
			if (mplier_q[0])
				prod_q <= prod_q + mcand_q;
			mcand_q  <= {mcand_q[WIDTH-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[WIDTH-1:1]};
		end
	end

	// restoring divider on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_cnt_q  <= '0;
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q + CW'(1);
				if (div_cnt_q == CW'(WIDTH - 1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sa_q  <= div_a[WIDTH-1];
			sb_q  <= div_b[WIDTH-1];
			dvd_q <= div_a[WIDTH-1] ? (WIDTH'(0) - div_a) : div_a;
			dvs_q <= div_b[WIDTH-1] ? (WIDTH'(0) - div_b) : div_b;
			rem_q <= '0;
			quo_q <= '0;
		end else if (div_busy_q) begin
			dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
			quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH]};
			rem_q <= diff[WIDTH] ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
		end
	end

	// operand capture and register writes
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.operation;
			an_q  <= WIDTH'(req.a_num);
			ad_q  <= WIDTH'(req.a_den);
			bn_q  <= WIDTH'(req.b_num);
			bd_q  <= WIDTH'(req.b_den);
			iv_q  <= WIDTH'(req.int_value);
			rn_q  <= '0;
			rd_q  <= '0;
			eq_q  <= 1'b0;
			err_q <= 1'b0;
		end else begin
			unique case (cmd.wr)
				rag_pkg::WR_N_AN_D_AD: begin n_q <= an_q; d_q <= ad_q; end
				rag_pkg::WR_N_P:       n_q <= prod_q;
				rag_pkg::WR_N_ADD_P:   n_q <= n_q + prod_q;
				rag_pkg::WR_INT: begin
					n_q <= (op_q == rag_pkg::OP_ADD_INT) ? (an_q + prod_q) : (prod_q - an_q);
					d_q <= ad_q;
				end
				rag_pkg::WR_D_P:       d_q <= prod_q;
				rag_pkg::WR_EQ:        eq_q <= (n_q == prod_q);
				rag_pkg::WR_XY_INIT: begin x_q <= n_q; y_q <= d_q; end
				rag_pkg::WR_STEP:    begin x_q <= y_q; y_q <= r_res; end
				rag_pkg::WR_RN_Q:      rn_q <= q_res;
				rag_pkg::WR_RD_Q:      rd_q <= q_res;
				rag_pkg::WR_ERR:       err_q <= 1'b1;
				default: ;
			endcase
		end
	end

	assign status.op       = op_q;
	assign status.mul_done = mul_done_q;
	assign status.div_done = div_done_q;
	assign status.d_zero   = (d_q == '0);
	assign status.rem_zero = (rem_q == '0);

	assign res.res_num      = 32'(rn_q);
	assign res.res_den      = 32'(rd_q);
	assign res.is_equal     = eq_q;
	assign res.divide_error = err_q;

	`RAG_ASSERT(a_mul_start_idle, clk, arst_n, cmd.mul_start |-> !mul_busy_q)
	`RAG_ASSERT(a_div_start_idle, clk, arst_n, cmd.div_start |-> !div_busy_q)
	`RAG_ASSERT(a_units_exclusive, clk, arst_n, !(mul_busy_q && div_busy_q))

endmodule

FILE: hw/rtl/rag_ctrl.sv
// ----------------------------------------------------------------------------
// rag_ctrl
// sequencer for the operation products and the euclid reduction loop
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rag_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic                out_free,
	input  rag_pkg::dp_status_t status,
	output rag_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD1,
		S_ADD2,
		S_ADD3,
		S_INT1,
		S_EQ1,
		S_EQ2,
		S_SETTLE,
		S_CHECK,
		S_REM_GO,
		S_REM_WAIT,
		S_QN,
		S_QD,
		S_OUT
	} state_t;

	state_t            state_q;
	rag_pkg::ctl_cmd_t cmd_q;

	assign req_stall = (state_q != S_IDLE);

	// load goes straight to the datapath on accept
	always_comb begin
		cmd      = cmd_q;
		cmd.load = req_valid && (state_q == S_IDLE);
	end

	// state and registered commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
		end else begin
			cmd_q <= '0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid)
						state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					priority case (status.op)
						rag_pkg::OP_NORM: begin
							cmd_q.wr <= rag_pkg::WR_N_AN_D_AD;
							state_q  <= S_SETTLE;
						end
						rag_pkg::OP_ADD: begin
							cmd_q.mul_start <= 1'b1;
							cmd_q.mul_sel   <= rag_pkg::MUL_AN_BD;
							state_q         <= S_ADD1;
						end
						rag_pkg::OP_ADD_INT, rag_pkg::OP_SUB_INT: begin
							cmd_q.mul_start <= 1'b1;
							cmd_q.mul_sel   <= rag_pkg::MUL_IV_AD;
							state_q         <= S_INT1;
						end
						rag_pkg::OP_EQ: begin
							cmd_q.mul_start <= 1'b1;
							cmd_q.mul_sel   <= rag_pkg::MUL_AN_BD;
							state_q         <= S_EQ1;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_ADD1: begin
					if (status.mul_done) begin
						cmd_q.wr        <= rag_pkg::WR_N_P;
						cmd_q.mul_start <= 1'b1;
						cmd_q.mul_sel   <= rag_pkg::MUL_BN_AD;
						state_q         <= S_ADD2;
					end
				end
				S_ADD2: begin
					if (status.mul_done) begin
						cmd_q.wr        <= rag_pkg::WR_N_ADD_P;
						cmd_q.mul_start <= 1'b1;
						cmd_q.mul_sel   <= rag_pkg::MUL_AD_BD;
						state_q         <= S_ADD3;
					end
				end
				S_ADD3: begin
					if (status.mul_done) begin
						cmd_q.wr <= rag_pkg::WR_D_P;
						state_q  <= S_SETTLE;
					end
				end
				S_INT1: begin
					if (status.mul_done) begin
						cmd_q.wr <= rag_pkg::WR_INT;
						state_q  <= S_SETTLE;
					end
				end
				S_EQ1: begin
					if (status.mul_done) begin
						cmd_q.wr        <= rag_pkg::WR_N_P;
						cmd_q.mul_start <= 1'b1;
						cmd_q.mul_sel   <= rag_pkg::MUL_BN_AD;
						state_q         <= S_EQ2;
					end
				end
				S_EQ2: begin
					if (status.mul_done) begin
						cmd_q.wr <= rag_pkg::WR_EQ;
						state_q  <= S_OUT;
					end
				end
				// numerator and denominator written this cycle
				S_SETTLE: state_q <= S_CHECK;
				S_CHECK: begin
					if (status.d_zero) begin
						cmd_q.wr <= rag_pkg::WR_ERR;
						state_q  <= S_OUT;
					end else begin
						cmd_q.wr <= rag_pkg::WR_XY_INIT;
						state_q  <= S_REM_GO;
					end
				end
				S_REM_GO: begin
					cmd_q.div_start <= 1'b1;
					cmd_q.div_sel   <= rag_pkg::DIV_X_Y;
					state_q         <= S_REM_WAIT;
				end
				// euclid loop: stop on a zero remainder
				S_REM_WAIT: begin
					if (status.div_done) begin
						if (status.rem_zero) begin
							cmd_q.div_start <= 1'b1;
							cmd_q.div_sel   <= rag_pkg::DIV_N_Y;
							state_q         <= S_QN;
						end else begin
							cmd_q.wr <= rag_pkg::WR_STEP;
							state_q  <= S_REM_GO;
						end
					end
				end
				S_QN: begin
					if (status.div_done) begin
						cmd_q.wr        <= rag_pkg::WR_RN_Q;
						cmd_q.div_start <= 1'b1;
						cmd_q.div_sel   <= rag_pkg::DIV_D_Y;
						state_q         <= S_QD;
					end
				end
				S_QD: begin
					if (status.div_done) begin
						cmd_q.wr <= rag_pkg::WR_RD_Q;
						state_q  <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						cmd_q.out_load <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RAG_ASSERT(a_out_from_out, clk, arst_n, cmd_q.out_load |-> $past(state_q == S_OUT))
	`RAG_ASSERT(a_rem_hold, clk, arst_n,
		(state_q == S_REM_WAIT && !status.div_done) |=> (state_q == S_REM_WAIT))
	`RAG_ASSERT(a_load_idle, clk, arst_n, cmd.load |=> (state_q == S_DISPATCH))

endmodule
